// ----- hdl/sbpf_pkg.sv -----
// Shared types and constants for the spectrum bar peak/fall meter.
`timescale 1ns / 1ps

package sbpf_pkg;

  localparam int COL_W     = 6;
  localparam int BIN_W     = 7;
  localparam int MAG_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_SPEED_INIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_ACCEL      = 2'd1;

  localparam logic [CFG_W-1:0] FALL_SPEED_INIT_RST = 16'd256;
  localparam logic [CFG_W-1:0] FALL_ACCEL_RST      = 16'd34406;

  // (mag << 8) / 6 == floor(mag * TGT_MUL / 2^18) for every 16-bit mag
  localparam logic [23:0] TGT_MUL   = 24'd11184811;
  localparam int          TGT_SHIFT = 18;

  // (a >> 2) / 15 == floor((a >> 2) * DIV15_MUL / 2^33) for a <= 2^31
  localparam logic [29:0] DIV15_MUL   = 30'd572662307;
  localparam int          DIV15_SHIFT = 33;

  // Q1.15 rounding bias toward zero for negative products
  localparam logic [48:0] ACC_BIAS = 49'd32767;

  typedef struct packed {
    logic             vld;
    logic [COL_W-1:0] col;
    logic [MAG_W-1:0] mag;
  } sbpf_item_t;

  typedef struct packed {
    logic               vld;
    logic [COL_W-1:0]   col;
    logic signed [31:0] height;
    logic signed [31:0] velocity;
  } sbpf_res_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } sbpf_rgb_t;

endpackage

// ----- hdl/sbpf_stream_if.sv -----
// Valid/ready stream interfaces for spectrum bins and bar updates.
`timescale 1ns / 1ps

interface sbpf_bin_if;
  logic                        valid;
  logic                        ready;
  logic [sbpf_pkg::BIN_W-1:0]  bin_index;
  logic [sbpf_pkg::MAG_W-1:0]  magnitude;

  modport source (output valid, output bin_index, output magnitude, input ready);
  modport sink   (input valid, input bin_index, input magnitude, output ready);
endinterface

interface sbpf_bar_if;
  logic                        valid;
  logic                        ready;
  logic [sbpf_pkg::COL_W-1:0]  column;
  logic signed [31:0]          bar_level;
  logic [7:0]                  red;
  logic [7:0]                  green;
  logic [7:0]                  blue;

  modport source (output valid, output column, output bar_level,
                  output red, output green, output blue, input ready);
  modport sink   (input valid, input column, input bar_level,
                  input red, input green, input blue, output ready);
endinterface

// ----- hdl/sbpf_bar_mem.sv -----
// Height and velocity memories with per-entry valid bits (unwritten reads as zero).
`timescale 1ns / 1ps

module sbpf_bar_mem #(
  parameter int  DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic signed [31:0]  wr_height_i,
  input  logic signed [31:0]  wr_velocity_i,
  output logic signed [31:0]  rd_height_o,
  output logic signed [31:0]  rd_velocity_o
);

  logic signed [31:0] height_mem   [DEPTH];
  logic signed [31:0] velocity_mem [DEPTH];
  logic [DEPTH-1:0]   written_q;
  logic signed [31:0] rd_height_q;
  logic signed [31:0] rd_velocity_q;
  logic               rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      height_mem[wr_addr_i]   <= wr_height_i;
      velocity_mem[wr_addr_i] <= wr_velocity_i;
    end
    if (rd_en_i) begin
      rd_height_q   <= height_mem[rd_addr_i];
      rd_velocity_q <= velocity_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_height_o   = rd_written_q ? rd_height_q   : '0;
  assign rd_velocity_o = rd_written_q ? rd_velocity_q : '0;

endmodule

// ----- hdl/sbpf_fall_calc.sv -----
// Two-stage bar update: products in the first stage, compare/saturate in the second.
`timescale 1ns / 1ps

module sbpf_fall_calc (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  sbpf_pkg::sbpf_item_t         item_i,
  input  logic signed [31:0]           height_i,
  input  logic signed [31:0]           velocity_i,
  input  logic [sbpf_pkg::CFG_W-1:0]   fall_speed_init_i,
  input  logic [sbpf_pkg::CFG_W-1:0]   fall_accel_i,
  output sbpf_pkg::sbpf_res_t          res_o
);

  // first stage
  logic [31:0]        vel_abs;
  logic [59:0]        step_prod_d;
  logic [39:0]        tgt_prod_d;
  logic signed [48:0] acc_prod_d;

  always_comb begin
    vel_abs     = velocity_i[31] ? (~velocity_i + 32'd1) : velocity_i;
    step_prod_d = {30'b0, vel_abs[31:2]} * {30'b0, sbpf_pkg::DIV15_MUL};
    tgt_prod_d  = {24'b0, item_i.mag} * {16'b0, sbpf_pkg::TGT_MUL};
    acc_prod_d  = $signed({{17{velocity_i[31]}}, velocity_i})
                * $signed({33'b0, fall_accel_i});
  end

  logic                         s2_vld_q;
  logic [sbpf_pkg::COL_W-1:0]   s2_col_q;
  logic signed [31:0]           s2_height_q;
  logic                         s2_vneg_q;
  logic [59:0]                  s2_step_prod_q;
  logic [39:0]                  s2_tgt_prod_q;
  logic signed [48:0]           s2_acc_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= item_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_col_q       <= item_i.col;
      s2_height_q    <= height_i;
      s2_vneg_q      <= velocity_i[31];
      s2_step_prod_q <= step_prod_d;
      s2_tgt_prod_q  <= tgt_prod_d;
      s2_acc_prod_q  <= acc_prod_d;
    end
  end

  // second stage
  logic signed [31:0] target;
  logic [26:0]        step_mag;
  logic signed [32:0] step_s;
  logic signed [32:0] height_sum;
  logic signed [31:0] height_fall;
  logic signed [48:0] acc_biased;
  logic signed [33:0] vel_scaled;
  logic signed [31:0] vel_fall;
  logic signed [31:0] vel_init;
  logic               jump;

  always_comb begin
    target     = $signed({10'b0, s2_tgt_prod_q[39:sbpf_pkg::TGT_SHIFT]});
    step_mag   = s2_step_prod_q[59:sbpf_pkg::DIV15_SHIFT];
    step_s     = s2_vneg_q ? -$signed({6'b0, step_mag}) : $signed({6'b0, step_mag});
    height_sum = $signed({s2_height_q[31], s2_height_q}) + step_s;
    if (height_sum[32] != height_sum[31]) begin
      height_fall = height_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      height_fall = height_sum[31:0];
    end

    // truncate toward zero: bias negative products before the shift
    acc_biased = s2_acc_prod_q + (s2_vneg_q ? $signed(sbpf_pkg::ACC_BIAS) : 49'sd0);
    vel_scaled = acc_biased[48:15];
    if ((vel_scaled[33:31] != 3'b000) && (vel_scaled[33:31] != 3'b111)) begin
      vel_fall = vel_scaled[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      vel_fall = vel_scaled[31:0];
    end

    vel_init = -$signed({8'b0, fall_speed_init_i, 8'b0});
    jump     = s2_height_q < target;

    res_o.vld      = s2_vld_q;
    res_o.col      = s2_col_q;
    res_o.height   = jump ? target   : height_fall;
    res_o.velocity = jump ? vel_init : vel_fall;
  end

endmodule

// ----- hdl/spectrum_bar_peak_fall.sv -----
// Top level: bin intake, bar state read-modify-write, rainbow colour and output register.
// Path: the bin and its memory read are registered in the first stage, the products in
//   the calculator's second stage, and the finished result in the output register.
// Throughput: one bin per cycle while the output register is not stalled; an odd bin of
//   the column held in the first stage waits on the height/velocity memory interlock.
// Even and out-of-range bins are consumed and give no result.
// Reset: rst_ni asynchronous, active low; clears control state and per-column valid
//   bits, so bars read as zero height and zero velocity until written. No clearing pass.
`timescale 1ns / 1ps

module spectrum_bar_peak_fall #(
  parameter int COLUMNS = 64,
  parameter int BINS    = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sbpf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sbpf_pkg::CFG_W-1:0]       cfg_data_i,
  sbpf_bin_if.sink                         bin_i,
  sbpf_bar_if.source                       bar_o
);

  localparam int MaxCols = 1 << sbpf_pkg::COL_W;
  localparam int Depth   = (COLUMNS < MaxCols) ? COLUMNS : MaxCols;
  localparam int AW      = $clog2(Depth);
  localparam logic [9:0] BinsLim = 10'(BINS);
  localparam logic [8:0] ColsLim = 9'(COLUMNS);

  // configuration
  logic [sbpf_pkg::CFG_W-1:0] fall_speed_init_q;
  logic [sbpf_pkg::CFG_W-1:0] fall_accel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_speed_init_q <= sbpf_pkg::FALL_SPEED_INIT_RST;
      fall_accel_q      <= sbpf_pkg::FALL_ACCEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbpf_pkg::CFG_FALL_SPEED_INIT: fall_speed_init_q <= cfg_data_i;
        sbpf_pkg::CFG_FALL_ACCEL:      fall_accel_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // rainbow table, one entry per column
  sbpf_pkg::sbpf_rgb_t hue_tab [Depth];

  for (genvar c = 0; c < Depth; c++) begin : g_hue
    localparam int Scaled = 6 * c;
    localparam int Sector = Scaled / COLUMNS;
    localparam int Rem    = Scaled % COLUMNS;
    localparam int Rise   = (255 * Rem) / COLUMNS;
    localparam int Fall   = (255 * (COLUMNS - Rem)) / COLUMNS;
    localparam int Red    = (Sector == 0 || Sector == 5) ? 255 :
                            (Sector == 1) ? Fall : (Sector == 4) ? Rise : 0;
    localparam int Green  = (Sector == 0) ? Rise :
                            (Sector == 1 || Sector == 2) ? 255 : (Sector == 3) ? Fall : 0;
    localparam int Blue   = (Sector == 2) ? Rise :
                            (Sector == 3 || Sector == 4) ? 255 : (Sector == 5) ? Fall : 0;
    assign hue_tab[c] = '{red: 8'(Red), green: 8'(Green), blue: 8'(Blue)};
  end

  // intake
  logic                       en;
  logic                       hit;
  logic                       hazard;
  logic                       in_acc;
  logic [sbpf_pkg::COL_W-1:0] in_col;
  sbpf_pkg::sbpf_item_t       s1_q;
  sbpf_pkg::sbpf_res_t        res;
  logic                       out_vld_q;

  assign en     = !out_vld_q || bar_o.ready;
  assign in_col = bin_i.bin_index[sbpf_pkg::BIN_W-1:1];
  assign hit    = bin_i.bin_index[0] && ({3'b0, bin_i.bin_index} < BinsLim)
               && ({3'b0, in_col} < ColsLim);
  // the column still in the first stage has not been written back yet
  assign hazard = s1_q.vld && hit && (in_col == s1_q.col);
  assign bin_i.ready = en && !hazard;
  assign in_acc = bin_i.valid && bin_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en) begin
      s1_q.vld <= in_acc && hit;
      s1_q.col <= in_col;
      s1_q.mag <= bin_i.magnitude;
    end
  end

  // state memory and write-back forwarding
  logic signed [31:0]         mem_height;
  logic signed [31:0]         mem_velocity;
  logic                       wb_vld_q;
  logic [sbpf_pkg::COL_W-1:0] wb_col_q;
  logic signed [31:0]         wb_height_q;
  logic signed [31:0]         wb_velocity_q;
  logic                       fwd;
  logic signed [31:0]         s1_height;
  logic signed [31:0]         s1_velocity;

  sbpf_bar_mem #(
    .DEPTH(Depth)
  ) u_bar_mem (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_en_i       (en),
    .rd_addr_i     (in_col[AW-1:0]),
    .wr_en_i       (en && res.vld),
    .wr_addr_i     (res.col[AW-1:0]),
    .wr_height_i   (res.height),
    .wr_velocity_i (res.velocity),
    .rd_height_o   (mem_height),
    .rd_velocity_o (mem_velocity)
  );

  // write at the same edge as the read: the read saw the old entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_vld_q <= 1'b0;
    end else if (en) begin
      wb_vld_q <= res.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wb_col_q      <= res.col;
      wb_height_q   <= res.height;
      wb_velocity_q <= res.velocity;
    end
  end

  assign fwd         = wb_vld_q && (wb_col_q == s1_q.col);
  assign s1_height   = fwd ? wb_height_q   : mem_height;
  assign s1_velocity = fwd ? wb_velocity_q : mem_velocity;

  sbpf_fall_calc u_fall_calc (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .item_i            (s1_q),
    .height_i          (s1_height),
    .velocity_i        (s1_velocity),
    .fall_speed_init_i (fall_speed_init_q),
    .fall_accel_i      (fall_accel_q),
    .res_o             (res)
  );

  // output register
  logic [sbpf_pkg::COL_W-1:0] out_col_q;
  logic signed [31:0]         out_height_q;
  sbpf_pkg::sbpf_rgb_t        out_rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= res.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && res.vld) begin
      out_col_q    <= res.col;
      out_height_q <= res.height;
      out_rgb_q    <= hue_tab[res.col[AW-1:0]];
    end
  end

  assign bar_o.valid     = out_vld_q;
  assign bar_o.column    = out_col_q;
  assign bar_o.bar_level = out_height_q;
  assign bar_o.red       = out_rgb_q.red;
  assign bar_o.green     = out_rgb_q.green;
  assign bar_o.blue      = out_rgb_q.blue;

endmodule

// ----- hdl/sbpf_checker.sv -----
// Port-level assertions for the bar meter, bound to the top level.
`timescale 1ns / 1ps

module sbpf_checker #(
  parameter int COLUMNS = 64,
  parameter int BINS    = 128
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [sbpf_pkg::BIN_W-1:0] bin_index_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [sbpf_pkg::COL_W-1:0] column_i,
  input logic signed [31:0]         bar_level_i,
  input logic [7:0]                 red_i,
  input logic [7:0]                 green_i,
  input logic [7:0]                 blue_i
);

  logic in_acc;
  logic in_hit;

  assign in_acc = in_valid_i && in_ready_i;
  assign in_hit = bin_index_i[0] && ({3'b0, bin_index_i} < 10'(BINS))
               && ({3'b0, bin_index_i[sbpf_pkg::BIN_W-1:1]} < 9'(COLUMNS));

  // a result held against backpressure keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(column_i)
      && $stable(bar_level_i) && $stable(red_i) && $stable(green_i) && $stable(blue_i))
    else $error("bar result changed while stalled");

  // the first cycle out of reset carries no result
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("bar result valid right after reset");

  // a full-saturation rainbow colour has one channel at 255 and one at 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (red_i == 8'd255 || green_i == 8'd255 || blue_i == 8'd255)
      && (red_i == 8'd0 || green_i == 8'd0 || blue_i == 8'd0))
    else $error("bar colour is not a saturated hue");

  // read-modify-write interlock: same column is never taken in consecutive cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_hit && $past(rst_ni) && $past(in_acc) && $past(in_hit)
      |-> bin_index_i[sbpf_pkg::BIN_W-1:1] != $past(bin_index_i[sbpf_pkg::BIN_W-1:1]))
    else $error("same column accepted back to back");

endmodule

bind spectrum_bar_peak_fall sbpf_checker #(
  .COLUMNS(COLUMNS),
  .BINS   (BINS)
) u_sbpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (bin_i.valid),
  .in_ready_i  (bin_i.ready),
  .bin_index_i (bin_i.bin_index),
  .out_valid_i (bar_o.valid),
  .out_ready_i (bar_o.ready),
  .column_i    (bar_o.column),
  .bar_level_i (bar_o.bar_level),
  .red_i       (bar_o.red),
  .green_i     (bar_o.green),
  .blue_i      (bar_o.blue)
);

// ----- sim/spectrum_bar_peak_fall_tb.sv -----
// Self-checking testbench for the spectrum bar peak/fall meter.
`timescale 1ns / 1ps

module spectrum_bar_peak_fall_tb;

  localparam int COLUMNS     = 64;
  localparam int BINS        = 128;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYC  = 8;

  localparam longint TARGET_DIV = 6;
  localparam longint FRAME_RATE = 60;
  localparam longint ACCEL_ONE  = 32768;
  localparam int     CHAN_MAX   = 255;
  localparam longint HEIGHT_MAX = 64'sd2147483647;
  localparam longint HEIGHT_MIN = -64'sd2147483648;

  // unused register slots; writes there must not disturb anything
  localparam logic [sbpf_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [sbpf_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int {
    SECT_RED_YELLOW, SECT_YELLOW_GREEN, SECT_GREEN_CYAN,
    SECT_CYAN_BLUE, SECT_BLUE_MAGENTA, SECT_MAGENTA_RED
  } hue_sector_e;

  typedef struct packed {
    logic [sbpf_pkg::BIN_W-1:0] bin;
    logic [sbpf_pkg::MAG_W-1:0] mag;
  } bin_beat_t;

  typedef struct packed {
    logic [sbpf_pkg::COL_W-1:0] column;
    logic signed [31:0]         height;
    sbpf_pkg::sbpf_rgb_t        rgb;
  } bar_update_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we;
  logic [sbpf_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [sbpf_pkg::CFG_W-1:0]     cfg_data;
  logic                           hold_kick = 1'b0;
  int                             hold_left;

  sbpf_bin_if bin_if ();
  sbpf_bar_if bar_if ();

  spectrum_bar_peak_fall #(
    .COLUMNS(COLUMNS),
    .BINS   (BINS)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .bin_i     (bin_if.sink),
    .bar_o     (bar_if.source)
  );

  always #10 clk_i = ~clk_i;

  bin_beat_t   bin_pending[$];
  bar_update_t bar_expect[$];
  bin_beat_t   drv_beat;
  bar_update_t want_upd;

  // predictor state
  logic [sbpf_pkg::CFG_W-1:0] fall_speed_cfg;
  logic [sbpf_pkg::CFG_W-1:0] fall_accel_cfg;
  logic signed [31:0]         bar_level_mem[COLUMNS];
  logic signed [31:0]         bar_vel_mem[COLUMNS];

  // stimulus-side spectrum levels per column
  int level_mem[COLUMNS];

  int send_idle_pct;
  int recv_idle_pct;
  int n_mismatch;
  int n_updates;
  int n_bins_accepted;
  int n_odd_queued;
  int n_settings;
  int cycle_cnt;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_mismatch++;
    $display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
  endtask

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > HEIGHT_MAX) return HEIGHT_MAX[31:0];
    if (x < HEIGHT_MIN) return HEIGHT_MIN[31:0];
    return x[31:0];
  endfunction

  function automatic sbpf_pkg::sbpf_rgb_t rainbow(input logic [sbpf_pkg::COL_W-1:0] col);
    int                  scaled;
    int                  rem;
    int                  rise;
    int                  fall;
    sbpf_pkg::sbpf_rgb_t c;
    scaled = 6 * int'(col);
    rem    = scaled % COLUMNS;
    rise   = CHAN_MAX * rem / COLUMNS;
    fall   = CHAN_MAX * (COLUMNS - rem) / COLUMNS;
    unique case (hue_sector_e'(scaled / COLUMNS))
      SECT_RED_YELLOW:   c = '{8'(CHAN_MAX), 8'(rise), 8'd0};
      SECT_YELLOW_GREEN: c = '{8'(fall), 8'(CHAN_MAX), 8'd0};
      SECT_GREEN_CYAN:   c = '{8'd0, 8'(CHAN_MAX), 8'(rise)};
      SECT_CYAN_BLUE:    c = '{8'd0, 8'(fall), 8'(CHAN_MAX)};
      SECT_BLUE_MAGENTA: c = '{8'(rise), 8'd0, 8'(CHAN_MAX)};
      default:           c = '{8'(CHAN_MAX), 8'd0, 8'(fall)};
    endcase
    return c;
  endfunction

  // peak-hold / gravity-fall update of one column; even or out-of-range bins change nothing
  function automatic void predict_bar_update(input logic [sbpf_pkg::BIN_W-1:0] bin,
                                             input logic [sbpf_pkg::MAG_W-1:0] mag);
    logic [sbpf_pkg::COL_W-1:0] col;
    longint                     tgt;
    longint                     h;
    longint                     v;
    bar_update_t                upd;
    if (!bin[0] || int'(bin) >= BINS) return;
    col = bin[sbpf_pkg::BIN_W-1:1];
    if (int'(col) >= COLUMNS) return;
    tgt = (longint'(mag) << 8) / TARGET_DIV;
    h   = bar_level_mem[col];
    v   = bar_vel_mem[col];
    if (h < tgt) begin
      bar_level_mem[col] = clamp32(tgt);
      bar_vel_mem[col]   = clamp32(-(longint'(fall_speed_cfg) << 8));
    end else begin
      bar_level_mem[col] = clamp32(h + v / FRAME_RATE);
      bar_vel_mem[col]   = clamp32(v * longint'(fall_accel_cfg) / ACCEL_ONE);
    end
    upd.column = col;
    upd.height = bar_level_mem[col];
    upd.rgb    = rainbow(col);
    bar_expect.push_back(upd);
  endfunction

  // bin source
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_if.valid     <= 1'b0;
      bin_if.bin_index <= '0;
      bin_if.magnitude <= '0;
    end else if (!bin_if.valid || bin_if.ready) begin
      if (bin_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_beat = bin_pending.pop_front();
        bin_if.valid     <= 1'b1;
        bin_if.bin_index <= drv_beat.bin;
        bin_if.magnitude <= drv_beat.mag;
      end else begin
        bin_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_left <= 0;
    else if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bar_if.ready <= 1'b0;
    else bar_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // result checking, then prediction of the bin accepted at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (bar_if.valid && bar_if.ready) begin
        n_updates++;
        if (bar_expect.size() == 0) begin
          report_mismatch("update with none pending, column", bar_if.column, -1);
        end else begin
          want_upd = bar_expect.pop_front();
          if (bar_if.column !== want_upd.column)
            report_mismatch("column", bar_if.column, want_upd.column);
          if (bar_if.bar_level !== want_upd.height)
            report_mismatch("bar_level", bar_if.bar_level, want_upd.height);
          if (bar_if.red !== want_upd.rgb.red)
            report_mismatch("red", bar_if.red, want_upd.rgb.red);
          if (bar_if.green !== want_upd.rgb.green)
            report_mismatch("green", bar_if.green, want_upd.rgb.green);
          if (bar_if.blue !== want_upd.rgb.blue)
            report_mismatch("blue", bar_if.blue, want_upd.rgb.blue);
        end
      end
      if (bin_if.valid && bin_if.ready) begin
        n_bins_accepted++;
        predict_bar_update(bin_if.bin_index, bin_if.magnitude);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d updates outstanding", cycle_cnt,
               bar_expect.size());
      $display("[spectrum_bar_peak_fall] ERROR");
      $finish;
    end
  end

  task automatic push_bin(input logic [sbpf_pkg::BIN_W-1:0] bin,
                          input logic [sbpf_pkg::MAG_W-1:0] mag);
    bin_beat_t b;
    b.bin = bin;
    b.mag = mag;
    bin_pending.push_back(b);
    if (bin[0]) n_odd_queued++;
  endtask

  // mostly decaying levels so bars keep falling, with fresh peaks now and then
  function automatic logic [sbpf_pkg::MAG_W-1:0] next_level(input int col);
    int pick;
    pick = $urandom_range(11);
    if (pick < 2) level_mem[col] = $urandom_range(16'hFFFF);
    else if (pick < 5) level_mem[col] = level_mem[col];
    else level_mem[col] = level_mem[col] - level_mem[col] / 8 - $urandom_range(3);
    if (level_mem[col] < 0) level_mem[col] = 0;
    return sbpf_pkg::MAG_W'(level_mem[col]);
  endfunction

  task automatic fill_random(input int n_odd);
    int                         goal;
    int                         kind;
    int                         start;
    int                         len;
    int                         b;
    int                         reps;
    logic [sbpf_pkg::MAG_W-1:0] m;
    goal = n_odd_queued + n_odd;
    while (n_odd_queued < goal) begin
      kind = $urandom_range(9);
      if (kind <= 5) begin
        // frame segment in bin order, as from an FFT
        start = $urandom_range(BINS - 1);
        len   = $urandom_range(8, 48);
        for (b = start; b < BINS && b < start + len; b++) begin
          if (b % 2 == 1) push_bin(sbpf_pkg::BIN_W'(b), next_level(b / 2));
          else push_bin(sbpf_pkg::BIN_W'(b), sbpf_pkg::MAG_W'($urandom));
        end
      end else if (kind <= 7) begin
        // back-to-back hits on one column
        b    = 2 * $urandom_range(COLUMNS - 1) + 1;
        reps = $urandom_range(2, 6);
        repeat (reps) push_bin(sbpf_pkg::BIN_W'(b), next_level(b / 2));
      end else begin
        if ($urandom_range(7) == 0) m = $urandom_range(1) ? '1 : '0;
        else m = sbpf_pkg::MAG_W'($urandom);
        push_bin(sbpf_pkg::BIN_W'($urandom), m);
      end
    end
  endtask

  task automatic set_register(input logic [sbpf_pkg::CFG_IDX_W-1:0] idx,
                              input logic [sbpf_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    unique case (idx)
      sbpf_pkg::CFG_FALL_SPEED_INIT: fall_speed_cfg = data;
      sbpf_pkg::CFG_FALL_ACCEL:      fall_accel_cfg = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // wait until every bin is taken and every update is back, then let the pipe drain
  task automatic settle();
    while (bin_pending.size() != 0 || bin_if.valid || bar_expect.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [sbpf_pkg::CFG_W-1:0] speed,
                           input logic [sbpf_pkg::CFG_W-1:0] accel,
                           input int send_pct, input int recv_pct, input int n_odd,
                           input bit long_hold);
    set_register(sbpf_pkg::CFG_FALL_SPEED_INIT, speed);
    set_register(sbpf_pkg::CFG_FALL_ACCEL, accel);
    n_settings++;
    @(negedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    fill_random(n_odd);
    if (long_hold) begin
      @(posedge clk_i);
      hold_kick <= 1'b1;
      @(posedge clk_i);
      hold_kick <= 1'b0;
    end
    settle();
  endtask

  initial begin
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    n_mismatch       = 0;
    n_updates        = 0;
    n_bins_accepted  = 0;
    n_odd_queued     = 0;
    n_settings       = 1;
    fall_speed_cfg   = sbpf_pkg::FALL_SPEED_INIT_RST;
    fall_accel_cfg   = sbpf_pkg::FALL_ACCEL_RST;
    for (int k = 0; k < COLUMNS; k++) begin
      bar_level_mem[k] = '0;
      bar_vel_mem[k]   = '0;
      level_mem[k]     = 0;
    end
    send_idle_pct = 7;
    recv_idle_pct = 57;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero bars, full scale, equal-height falls, even bins, hue sectors
    push_bin(7'd1, 16'h0000);
    push_bin(7'd0, 16'hFFFF);
    push_bin(7'd127, 16'hFFFF);
    push_bin(7'd127, 16'hFFFF);
    push_bin(7'd127, 16'hFFFF);
    repeat (3) push_bin(7'd127, 16'h0000);
    push_bin(7'd126, 16'hFFFF);
    push_bin(7'd1, 16'h0001);
    push_bin(7'd1, 16'h0000);
    push_bin(7'd21, 16'h7FFF);
    push_bin(7'd23, 16'hFFFF);
    push_bin(7'd45, 16'h8000);
    push_bin(7'd65, 16'h00FF);
    push_bin(7'd87, 16'h5555);
    push_bin(7'd107, 16'h0100);
    push_bin(7'd109, 16'hAAAA);
    push_bin(7'd64, 16'h1234);
    settle();

    set_register(CFG_SPARE_LO, sbpf_pkg::CFG_W'($urandom));
    set_register(CFG_SPARE_HI, sbpf_pkg::CFG_W'($urandom));
    @(negedge clk_i);
    fill_random(75);
    settle();

    run_phase('0, '0, 7, 57, 100, 1'b0);
    run_phase('1, '1, 57, 7, 100, 1'b0);
    run_phase(sbpf_pkg::CFG_W'($urandom), sbpf_pkg::CFG_W'($urandom), 57, 7, 100, 1'b0);
    run_phase(16'd1, 16'd32768, 0, 0, 100, 1'b1);
    run_phase(sbpf_pkg::CFG_W'($urandom_range(4095)),
              sbpf_pkg::CFG_W'($urandom_range(32768, 65535)), 0, 0, 125, 1'b0);

    repeat (SETTLE_CYC) @(posedge clk_i);
    $display("bins accepted: %0d (%0d odd), bar updates checked: %0d, mismatches: %0d",
             n_bins_accepted, n_odd_queued, n_updates, n_mismatch);
    $display("register settings: %0d incl. both extremes, with stalls on either side",
             n_settings);
    if (n_mismatch == 0) begin
      $display("[spectrum_bar_peak_fall] OK");
    end else begin
      $display("[spectrum_bar_peak_fall] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sbpf_pkg.sv
hdl/sbpf_stream_if.sv
hdl/sbpf_bar_mem.sv
hdl/sbpf_fall_calc.sv
hdl/spectrum_bar_peak_fall.sv
hdl/sbpf_checker.sv
sim/spectrum_bar_peak_fall_tb.sv
